[design/ssn_pkg.sv]
// Shared types and constants for the surface strip normal block.
`default_nettype none

package ssn_pkg;

    localparam int COORD_W     = 32;
    localparam int NORM_W      = 16;
    localparam int MAG_W       = COORD_W + 1;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int NORM_BITS   = 30;
    localparam int SHIFT_STEPS = $clog2(PROD_W);
    localparam int SQ_W        = 2 * NORM_BITS;
    localparam int SUM_W       = SQ_W + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int DIV_NUM_W   = NORM_BITS + NORM_W;
    localparam int DIV_LAST    = NORM_W + 1;
    localparam int STEP_MAX_A  = (ROOT_W > DIV_LAST) ? ROOT_W : DIV_LAST;
    localparam int STEP_MAX    = (STEP_MAX_A > SHIFT_STEPS) ? STEP_MAX_A : SHIFT_STEPS;
    localparam int STEP_W      = $clog2(STEP_MAX + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_Z_STEP = CFG_IDX_W'(1);

    localparam logic [1:0] MODE_BOTH = 2'd0;
    localparam logic [1:0] MODE_PREV = 2'd1;
    localparam logic [1:0] MODE_NEXT = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    localparam logic signed [COORD_W-1:0] Z_STEP_RESET = COORD_W'(65536);

    typedef struct packed {
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_here;
        logic signed [COORD_W-1:0] y_prev;
        logic signed [COORD_W-1:0] y_next;
        logic                      strip_end;
    } t_in_item;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     final_normal;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W:0] tx;
        logic signed [COORD_W:0] ty;
        logic signed [COORD_W:0] sdy;
        logic                    last;
    } t_job;

    typedef struct packed {
        logic              accept;
        logic [1:0]        comp;
        logic [STEP_W-1:0] step;
        logic              mul_en;
        logic              norm_en;
        logic              sq_en;
        logic              acc_clr;
        logic              acc_en;
        logic              root_init;
        logic              root_en;
        logic              div_init;
        logic              div_en;
        logic              div_store;
        logic              load_out;
        logic              next_job;
    } t_cmd;

    typedef struct packed {
        logic has_job;
        logic more_jobs;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[design/surface_strip_normals.sv]
// Top level of the surface strip normal block: configuration registers and core.
`default_nettype none

// Points of a strip enter one at a time; each point's unit normal (Q1.15) leaves
// one point late, and the strip's last point releases two normals. A point that
// yields no normal returns to idle from the start state; one that yields normals
// holds the input until its last normal is loaded into the output register, which
// includes any wait for that register to empty. Each normal is computed by the
// shared bit-serial square root (31 steps) and the bit-serial divider (one
// component after another, three components) behind one cross-product multiplier.
// Slice mode 3 suppresses output. Configuration writes are accepted at any time;
// make them only while no point is in flight.
module surface_strip_normals
    import ssn_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data
);

    logic [1:0]                r_slice_mode;
    logic signed [COORD_W-1:0] r_z_step;
    t_cmd                      cmd;
    t_status                   status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_mode <= MODE_NONE;
            r_z_step     <= Z_STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SLICE_MODE:   r_slice_mode <= i_cfg_data[1:0];
                REG_SLICE_Z_STEP: r_z_step     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ssn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ssn_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in         (i_in),
        .i_slice_mode (r_slice_mode),
        .i_z_step     (r_z_step),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out)
    );

`ifndef SYNTHESIS
    a_no_min_component: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.norm_x != {1'b1, {(NORM_W-1){1'b0}}})
                     && (o_out.norm_y != {1'b1, {(NORM_W-1){1'b0}}})
                     && (o_out.norm_z != {1'b1, {(NORM_W-1){1'b0}}}))
        else $error("normal component outside saturated range");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result loaded while idle");

    a_no_result_mode_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && r_slice_mode == MODE_NONE) |=> ##1 !cmd.mul_en)
        else $error("normal started with slice mode none");
`endif

endmodule

`default_nettype wire

[design/ssn_ctrl.sv]
// Sequencer that steps the normal datapath through its phases.
`default_nettype none

module ssn_ctrl
    import ssn_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_MUL, S_NORM, S_SQ, S_ROOT, S_DIV, S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_comp, n_comp;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_step  = r_step + STEP_W'(1);
        n_comp  = r_comp;
        o_cmd.step = r_step;
        o_cmd.comp = r_step[1:0];
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                n_step  = '0;
                n_state = i_status.has_job ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == STEP_W'(2)) begin
                    n_state = S_NORM;
                    n_step  = '0;
                end
            end
            S_NORM: begin
                o_cmd.norm_en = 1'b1;
                if (r_step == STEP_W'(SHIFT_STEPS - 1)) begin
                    n_state = S_SQ;
                    n_step  = '0;
                end
            end
            S_SQ: begin
                o_cmd.sq_en   = (r_step < STEP_W'(3));
                o_cmd.acc_clr = (r_step == '0);
                o_cmd.acc_en  = (r_step != '0);
                if (r_step == STEP_W'(3)) begin
                    n_state = S_ROOT;
                    n_step  = '0;
                end
            end
            S_ROOT: begin
                o_cmd.root_init = (r_step == '0);
                o_cmd.root_en   = (r_step != '0);
                if (r_step == STEP_W'(ROOT_W)) begin
                    n_state = S_DIV;
                    n_step  = '0;
                    n_comp  = COMP_X;
                end
            end
            S_DIV: begin
                o_cmd.comp      = r_comp;
                o_cmd.div_init  = (r_step == '0);
                o_cmd.div_en    = (r_step != '0) && (r_step != STEP_W'(DIV_LAST));
                o_cmd.div_store = (r_step == STEP_W'(DIV_LAST));
                if (r_step == STEP_W'(DIV_LAST)) begin
                    n_step = '0;
                    if (r_comp == COMP_Z) n_state = S_OUT;
                    else n_comp = r_comp + 2'd1;
                end
            end
            S_OUT: begin
                n_step = '0;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.next_job = 1'b1;
                    n_state = i_status.more_jobs ? S_MUL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_comp  <= COMP_X;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_comp  <= n_comp;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[design/ssn_dp.sv]
// Datapath: point window, cross product, normalize, square root, divide, output register.
`default_nettype none

module ssn_dp
    import ssn_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    input  wire t_in_item                  i_in,
    input  wire logic [1:0]                i_slice_mode,
    input  wire logic signed [COORD_W-1:0] i_z_step,
    input  wire logic                      i_out_stall,
    output t_status                        o_status,
    output logic                           o_out_valid,
    output t_out_item                      o_out
);

    function automatic logic [MAG_W-1:0] mag(input logic signed [COORD_W:0] v);
        mag = v[COORD_W] ? (~v + MAG_W'(1)) : v;
    endfunction

    logic signed [COORD_W:0] r_older_x, r_older_y, r_held_x, r_held_y, r_held_dy;
    logic [1:0]              r_ps;
    t_job                    r_job0, r_job1;
    logic [1:0]              r_cnt;
    logic                    r_sel;

    logic signed [COORD_W:0] x_e, yh_e, yp_e, yn_e, dy, bx, by;
    logic                    live;
    t_job                    job0, job1, cur;

    always_comb begin
        x_e  = {i_in.x_pos[COORD_W-1], i_in.x_pos};
        yh_e = {i_in.y_here[COORD_W-1], i_in.y_here};
        yp_e = {i_in.y_prev[COORD_W-1], i_in.y_prev};
        yn_e = {i_in.y_next[COORD_W-1], i_in.y_next};
        unique case (i_slice_mode)
            MODE_BOTH: dy = yn_e - yp_e;
            MODE_PREV: dy = yh_e - yp_e;
            MODE_NEXT: dy = yn_e - yh_e;
            default:   dy = '0;
        endcase
        live = (i_slice_mode != MODE_NONE);
        bx   = (r_ps == 2'd1) ? r_held_x : r_older_x;
        by   = (r_ps == 2'd1) ? r_held_y : r_older_y;
        job0.tx   = x_e - bx;
        job0.ty   = yh_e - by;
        job0.sdy  = r_held_dy;
        job0.last = 1'b0;
        job1.tx   = x_e - r_held_x;
        job1.ty   = yh_e - r_held_y;
        job1.sdy  = dy;
        job1.last = 1'b1;
        cur = r_sel ? r_job1 : r_job0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older_x <= '0;
            r_older_y <= '0;
            r_held_x  <= '0;
            r_held_y  <= '0;
            r_held_dy <= '0;
            r_ps      <= 2'd0;
            r_cnt     <= 2'd0;
            r_sel     <= 1'b0;
        end else if (i_cmd.accept) begin
            r_older_x <= r_held_x;
            r_older_y <= r_held_y;
            r_held_x  <= x_e;
            r_held_y  <= yh_e;
            r_held_dy <= dy;
            if (i_in.strip_end) r_ps <= 2'd0;
            else if (r_ps != 2'd2) r_ps <= r_ps + 2'd1;
            r_job0 <= job0;
            r_job1 <= job1;
            r_sel  <= 1'b0;
            if (r_ps != 2'd0 && live) r_cnt <= i_in.strip_end ? 2'd2 : 2'd1;
            else r_cnt <= 2'd0;
        end else if (i_cmd.next_job) begin
            r_sel <= 1'b1;
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // cross product magnitudes
    logic signed [COORD_W:0] dz_e;
    logic [MAG_W-1:0]        mul_a, mul_b;
    logic                    mul_neg;
    logic [PROD_W-1:0]       r_c [3];
    logic                    r_neg [3];

    always_comb begin
        dz_e = {i_z_step[COORD_W-1], i_z_step};
        case (i_cmd.comp)
            COMP_X: begin
                mul_a   = mag(cur.ty);
                mul_b   = mag(dz_e);
                mul_neg = cur.ty[COORD_W] ^ dz_e[COORD_W];
            end
            COMP_Y: begin
                mul_a   = mag(cur.tx);
                mul_b   = mag(dz_e);
                mul_neg = ~(cur.tx[COORD_W] ^ dz_e[COORD_W]);
            end
            default: begin
                mul_a   = mag(cur.tx);
                mul_b   = mag(cur.sdy);
                mul_neg = cur.tx[COORD_W] ^ cur.sdy[COORD_W];
            end
        endcase
    end

    logic [PROD_W-1:0]      or_all;
    logic [SHIFT_STEPS-1:0] norm_amt;
    logic                   top_zero;
    logic [NORM_BITS-1:0]   m [3];

    always_comb begin
        or_all   = r_c[0] | r_c[1] | r_c[2];
        norm_amt = SHIFT_STEPS'(1) << (SHIFT_STEPS - 1 - int'(i_cmd.step));
        top_zero = ((or_all >> (PROD_W - int'(norm_amt))) == '0);
        for (int j = 0; j < 3; j++) m[j] = r_c[j][PROD_W-1 -: NORM_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.comp)
                COMP_X:  begin r_c[0] <= mul_a * mul_b; r_neg[0] <= mul_neg; end
                COMP_Y:  begin r_c[1] <= mul_a * mul_b; r_neg[1] <= mul_neg; end
                default: begin r_c[2] <= mul_a * mul_b; r_neg[2] <= mul_neg; end
            endcase
        end else if (i_cmd.norm_en && top_zero) begin
            for (int j = 0; j < 3; j++) r_c[j] <= r_c[j] << norm_amt;
        end
    end

    // sum of squares
    logic [SQ_W-1:0]  r_sq;
    logic [SUM_W-1:0] r_sum;
    logic [NORM_BITS-1:0] sq_in;

    assign sq_in = (i_cmd.comp == COMP_X) ? m[0] : (i_cmd.comp == COMP_Y) ? m[1] : m[2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) r_sq <= sq_in * sq_in;
        if (i_cmd.acc_clr) r_sum <= '0;
        else if (i_cmd.acc_en) r_sum <= r_sum + SUM_W'(r_sq);
    end

    // square root, two bits per step
    logic [SUM_W-1:0]  r_rn;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+1:0] rem_sh, trial;

    assign rem_sh = {r_rem[ROOT_W-1:0], r_rn[SUM_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_rn   <= r_sum;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_en) begin
            r_rn <= r_rn << 2;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // restoring division, one quotient bit per step
    localparam logic [NORM_W-1:0] MAXV = {1'b0, {(NORM_W-1){1'b1}}};

    logic [DIV_NUM_W-1:0] div_num;
    logic [ROOT_W-1:0]    r_drem;
    logic [NORM_W-1:0]    r_dlo, r_q, q_sat, q_fin;
    logic [ROOT_W:0]      div_t;
    logic [NORM_W-1:0]    r_n [3];
    logic                 cur_neg;

    always_comb begin
        div_num = (DIV_NUM_W'(sq_in) << (NORM_W - 1)) + DIV_NUM_W'(r_root >> 1);
        div_t   = {r_drem, r_dlo[NORM_W-1]};
        q_sat   = (r_q > MAXV) ? MAXV : r_q;
        q_fin   = (r_root == '0) ? '0 : q_sat;
        cur_neg = (i_cmd.comp == COMP_X) ? r_neg[0] : (i_cmd.comp == COMP_Y) ? r_neg[1] : r_neg[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_drem <= ROOT_W'(div_num[DIV_NUM_W-1:NORM_W]);
            r_dlo  <= div_num[NORM_W-1:0];
        end else if (i_cmd.div_en) begin
            r_dlo <= r_dlo << 1;
            if (div_t >= {1'b0, r_root}) begin
                r_drem <= ROOT_W'(div_t - {1'b0, r_root});
                r_q    <= {r_q[NORM_W-2:0], 1'b1};
            end else begin
                r_drem <= div_t[ROOT_W-1:0];
                r_q    <= {r_q[NORM_W-2:0], 1'b0};
            end
        end else if (i_cmd.div_store) begin
            case (i_cmd.comp)
                COMP_X:  r_n[0] <= cur_neg ? (~q_fin + NORM_W'(1)) : q_fin;
                COMP_Y:  r_n[1] <= cur_neg ? (~q_fin + NORM_W'(1)) : q_fin;
                default: r_n[2] <= cur_neg ? (~q_fin + NORM_W'(1)) : q_fin;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out.norm_x       <= r_n[0];
            o_out.norm_y       <= r_n[1];
            o_out.norm_z       <= r_n[2];
            o_out.final_normal <= cur.last;
        end
    end

    assign o_status.has_job   = (r_cnt != 2'd0);
    assign o_status.more_jobs = (r_cnt == 2'd2);
    assign o_status.out_free  = !o_out_valid || !i_out_stall;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench for surface_strip_normals: random and directed strips checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import ssn_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COORD_W-1:0] i_cfg_data;

    surface_strip_normals dut (.*);

    t_in_item point_queue[$];
    t_out_item normal_queue[$];
    int send_idle_pct;
    int recv_stall_pct;
    int failures;
    logic in_sent;

    logic [1:0] p_mode;
    logic signed [63:0] p_dz;
    logic signed [63:0] p_older_x, p_older_y, p_held_x, p_held_y, p_held_dy;
    int p_seen;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [127:0] mag128(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int bit_len(logic [127:0] v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic predict_normal(logic signed [63:0] tx, logic signed [63:0] ty,
                                  logic signed [63:0] sdy, logic last);
        logic signed [127:0] c[3];
        logic [127:0] cm[3];
        logic [63:0] m[3];
        logic [63:0] sum, len, q;
        logic [15:0] r[3];
        int top, sh;
        t_out_item o;
        c[0] = 128'(ty) * 128'(p_dz);
        c[1] = -(128'(tx) * 128'(p_dz));
        c[2] = 128'(tx) * 128'(sdy);
        top = 0;
        for (int j = 0; j < 3; j++) begin
            cm[j] = mag128(c[j]);
            if (bit_len(cm[j]) > top) top = bit_len(cm[j]);
        end
        sh = top - NORM_BITS;
        sum = 0;
        for (int j = 0; j < 3; j++) begin
            if (top == 0) m[j] = 0;
            else if (sh < 0) m[j] = 64'(cm[j] << (-sh));
            else m[j] = 64'(cm[j] >> sh);
            sum += m[j] * m[j];
        end
        len = int_sqrt(sum);
        for (int j = 0; j < 3; j++) begin
            q = 0;
            if (len != 0) begin
                q = ((m[j] << 15) + len / 2) / len;
                if (q > 32767) q = 32767;
            end
            if (c[j] < 0) q = -q;
            r[j] = q[15:0];
        end
        o.norm_x = r[0];
        o.norm_y = r[1];
        o.norm_z = r[2];
        o.final_normal = last;
        normal_queue.push_back(o);
    endtask

    task automatic predict_point(t_in_item it);
        logic signed [63:0] x, yh, yp, yn, dy, bx, by;
        logic live;
        x = 64'(it.x_pos);
        yh = 64'(it.y_here);
        yp = 64'(it.y_prev);
        yn = 64'(it.y_next);
        live = p_mode != MODE_NONE;
        case (p_mode)
            MODE_BOTH: dy = yn - yp;
            MODE_PREV: dy = yh - yp;
            MODE_NEXT: dy = yn - yh;
            default: dy = 0;
        endcase
        if (p_seen != 0) begin
            bx = p_seen == 1 ? p_held_x : p_older_x;
            by = p_seen == 1 ? p_held_y : p_older_y;
            if (live) predict_normal(x - bx, yh - by, p_held_dy, 1'b0);
            if (live && it.strip_end) predict_normal(x - p_held_x, yh - p_held_y, dy, 1'b1);
        end
        p_older_x = p_held_x;
        p_older_y = p_held_y;
        p_held_x = x;
        p_held_y = yh;
        p_held_dy = dy;
        if (it.strip_end) p_seen = 0;
        else if (p_seen < 2) p_seen++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_sent) begin
            if (point_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in <= point_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= $urandom_range(99) < recv_stall_pct;
    end

    // monitor
    always @(posedge i_clk) begin
        in_sent <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) predict_point(i_in);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (normal_queue.size() == 0) begin
                $display("%0t unexpected normal: actual %h", $time, o_out);
                failures++;
            end else if (normal_queue[0] !== o_out) begin
                $display("%0t normal mismatch: expected %h actual %h",
                         $time, normal_queue[0], o_out);
                failures++;
                void'(normal_queue.pop_front());
            end else begin
                void'(normal_queue.pop_front());
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(2000) - 1000;
            3: return ($urandom_range(200) - 100) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_point(logic last);
        t_in_item it;
        it.x_pos = rand_coord();
        it.y_here = rand_coord();
        it.y_prev = rand_coord();
        it.y_next = rand_coord();
        it.strip_end = last;
        point_queue.push_back(it);
    endtask

    task automatic add_fixed(logic [31:0] x, logic [31:0] y, logic [31:0] yp,
                             logic [31:0] yn, logic last);
        t_in_item it;
        it = '{x, y, yp, yn, last};
        point_queue.push_back(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_SLICE_MODE) p_mode = val[1:0];
        else if (idx == REG_SLICE_Z_STEP) p_dz = 64'(signed'(val));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (point_queue.size() != 0 || i_in_valid || normal_queue.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        int len;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_sent = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        failures = 0;
        p_mode = MODE_NONE;
        p_dz = 64'(Z_STEP_RESET);
        p_older_x = 0;
        p_older_y = 0;
        p_held_x = 0;
        p_held_y = 0;
        p_held_dy = 0;
        p_seen = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_point(1'b0);
        add_point(1'b1);
        drain();
        write_reg(REG_SLICE_MODE, MODE_BOTH);
        write_reg(2'd3, 32'h5);
        add_fixed(0, 0, 0, 0, 1'b1);
        add_fixed(0, 5, 1, 2, 1'b0);
        add_fixed(0, 5, 1, 2, 1'b1);
        add_fixed(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        add_fixed(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        add_fixed(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
        add_fixed(32'h10000, 32'h20000, 32'h10000, 32'h30000, 1'b0);
        add_fixed(32'h20000, 32'h30000, 32'h20000, 32'h40000, 1'b0);
        add_fixed(32'h30000, 32'h10000, 32'h0, 32'h50000, 1'b1);
        drain();
        write_reg(REG_SLICE_MODE, MODE_PREV);
        write_reg(REG_SLICE_Z_STEP, 32'h8000_0000);
        for (int i = 0; i < 4; i++) add_point(i == 3);
        drain();
        write_reg(REG_SLICE_MODE, MODE_NEXT);
        write_reg(REG_SLICE_Z_STEP, 32'h7fff_ffff);
        for (int i = 0; i < 4; i++) add_point(i == 3);
        drain();
        write_reg(REG_SLICE_Z_STEP, 32'h0);
        for (int i = 0; i < 3; i++) add_point(i == 2);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 78 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 78 : (ph % 4 == 3) ? 33 : 0;
            if (ph % 4 == 3) send_idle_pct = 33;
            write_reg(REG_SLICE_MODE, ph == 6 ? MODE_NONE : 2'($urandom_range(2)));
            case (ph % 3)
                0: write_reg(REG_SLICE_Z_STEP, 32'h10000);
                1: write_reg(REG_SLICE_Z_STEP, $urandom);
                default: write_reg(REG_SLICE_Z_STEP, 32'($urandom_range(400)) - 200);
            endcase
            for (int n = 0; n < 180; ) begin
                len = $urandom_range(9) == 0 ? 1 : $urandom_range(8, 2);
                for (int k = 0; k < len; k++) add_point(k == len - 1);
                n += len;
            end
            drain();
        end

        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
